// ----- design/sirt_pkg.sv -----
// sirt_pkg: shared constants, command codes and types of the retransmit table.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sirt_pkg;

    localparam int CMD_W    = 3;
    localparam int SEQ_W    = 32;
    localparam int STATE_W  = 2;
    localparam int DESC_W   = 32;
    localparam int TIME_W   = 32;
    localparam int OCC_W    = 9;
    localparam int CFG_W    = 4;
    localparam int MIN_LOG2 = 2;

    localparam int DEPTH_DEFAULT = 256;

    localparam logic [CFG_W-1:0] LOG2_CAP_RESET = 4'd8;

    localparam logic [CMD_W-1:0] CMD_INSERT    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE    = 3'd1;
    localparam logic [CMD_W-1:0] CMD_GET       = 3'd2;
    localparam logic [CMD_W-1:0] CMD_SET_STATE = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CLEAR     = 3'd4;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FAIL = 1'b1;

    localparam logic [STATE_W-1:0] SLOT_EMPTY = 2'd0;

    typedef struct packed {
        logic [SEQ_W-1:0]  tag;
        logic [DESC_W-1:0] descriptor;
        logic [TIME_W-1:0] sent_time;
    } sirt_payload_t;

    typedef struct packed {
        logic status_we;
        logic payload_we;
    } sirt_wr_ctl_t;

    typedef struct packed {
        logic               status;
        logic [STATE_W-1:0] entry_state;
        logic [DESC_W-1:0]  entry_descriptor;
        logic [TIME_W-1:0]  first_sent_time;
        logic [OCC_W-1:0]   occupancy;
    } sirt_result_t;

endpackage

`default_nettype wire

// ----- design/sirt_slot_mem.sv -----
// sirt_slot_mem: slot state memory and slot payload memory, one read and one write port.
// Read data registered, held while the read enable is low. Uses sirt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sirt_slot_mem #(
    parameter int DEPTH = sirt_pkg::DEPTH_DEFAULT,
    localparam int IW   = $clog2(DEPTH)
) (
    input  wire logic                            aclk,
    input  wire logic                            rd_en,
    input  wire logic [IW-1:0]                   rd_addr,
    output logic [sirt_pkg::STATE_W-1:0]         rd_status,
    output sirt_pkg::sirt_payload_t              rd_payload,
    input  wire sirt_pkg::sirt_wr_ctl_t          wr_ctl,
    input  wire logic [IW-1:0]                   wr_addr,
    input  wire logic [sirt_pkg::STATE_W-1:0]    wr_status,
    input  wire sirt_pkg::sirt_payload_t         wr_payload
);

    logic [sirt_pkg::STATE_W-1:0] status_mem [DEPTH];
    sirt_pkg::sirt_payload_t      payload_mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_ctl.status_we) begin
            status_mem[wr_addr] <= wr_status;
        end
        if (rd_en) begin
            rd_status <= status_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_ctl.payload_we) begin
            payload_mem[wr_addr] <= wr_payload;
        end
        if (rd_en) begin
            rd_payload <= payload_mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ----- design/sirt_cmd_unit.sv -----
// sirt_cmd_unit: slot index, read-modify-write of one command, occupancy count, clear sweep.
// Drives sirt_slot_mem. Uses sirt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sirt_cmd_unit #(
    parameter int DEPTH = sirt_pkg::DEPTH_DEFAULT,
    localparam int IW   = $clog2(DEPTH),
    localparam int CW   = $clog2(DEPTH + 1)
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic [sirt_pkg::CFG_W-1:0]      log2_capacity,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic [sirt_pkg::CMD_W-1:0]      in_cmd,
    input  wire logic [sirt_pkg::SEQ_W-1:0]      in_seq_num,
    input  wire logic [sirt_pkg::STATE_W-1:0]    in_new_state,
    input  wire logic [sirt_pkg::DESC_W-1:0]     in_descriptor,
    input  wire logic [sirt_pkg::TIME_W-1:0]     in_now_us,
    input  wire logic                            out_free,
    output logic                                 res_valid,
    output sirt_pkg::sirt_result_t               res,
    output logic                                 rd_en,
    output logic [IW-1:0]                        rd_addr,
    input  wire logic [sirt_pkg::STATE_W-1:0]    rd_status,
    input  wire sirt_pkg::sirt_payload_t         rd_payload,
    output sirt_pkg::sirt_wr_ctl_t               wr_ctl,
    output logic [IW-1:0]                        wr_addr,
    output logic [sirt_pkg::STATE_W-1:0]         wr_status,
    output sirt_pkg::sirt_payload_t              wr_payload
);

    localparam int LOG2_MAX = $clog2(DEPTH + 1) - 1;
    localparam int LW       = sirt_pkg::CFG_W + 1;

    logic                            s1_valid_reg, s1_valid_next;
    logic [sirt_pkg::CMD_W-1:0]      s1_cmd_reg;
    logic [sirt_pkg::SEQ_W-1:0]      s1_seq_reg;
    logic [sirt_pkg::STATE_W-1:0]    s1_state_reg;
    logic [sirt_pkg::DESC_W-1:0]     s1_desc_reg;
    logic [sirt_pkg::TIME_W-1:0]     s1_time_reg;
    logic [IW-1:0]                   s1_idx_reg;
    logic [CW-1:0]                   count_reg, count_next;
    logic                            sweep_reg, sweep_next;
    logic [IW-1:0]                   sweep_addr_reg, sweep_addr_next;

    logic            accept;
    logic            done;
    logic [LW-1:0]   l_eff;
    logic [IW-1:0]   mask;
    logic            occupied;
    logic            match;
    logic            ok;
    logic            st_we;
    logic            pl_we;
    logic [sirt_pkg::STATE_W-1:0] st_val;
    logic            start_sweep;

    // Effective capacity: at least 2^MIN_LOG2, at most the largest power of two in DEPTH.
    always_comb begin
        l_eff = {1'b0, log2_capacity};
        if (l_eff < LW'(sirt_pkg::MIN_LOG2)) begin
            l_eff = LW'(sirt_pkg::MIN_LOG2);
        end else if (l_eff > LW'(LOG2_MAX)) begin
            l_eff = LW'(LOG2_MAX);
        end
        for (int i = 0; i < IW; i++) begin
            mask[i] = LW'(i) < l_eff;
        end
    end

    assign in_ready = !s1_valid_reg && !sweep_reg;
    assign accept   = in_valid && in_ready;
    assign rd_en    = accept;
    assign rd_addr  = in_seq_num[IW-1:0] & mask;
    assign done     = s1_valid_reg && out_free;

    assign occupied = rd_status != sirt_pkg::SLOT_EMPTY;
    assign match    = occupied && (rd_payload.tag == s1_seq_reg);

    always_comb begin
        ok          = 1'b0;
        st_we       = 1'b0;
        pl_we       = 1'b0;
        st_val      = sirt_pkg::SLOT_EMPTY;
        start_sweep = 1'b0;
        count_next  = count_reg;
        res         = '0;
        res.status  = sirt_pkg::STATUS_FAIL;
        case (s1_cmd_reg)
            sirt_pkg::CMD_INSERT: begin
                ok     = !occupied && (s1_state_reg != sirt_pkg::SLOT_EMPTY);
                st_we  = ok;
                pl_we  = ok;
                st_val = s1_state_reg;
                if (ok) begin
                    count_next = count_reg + CW'(1);
                end
            end
            sirt_pkg::CMD_REMOVE: begin
                ok    = occupied;
                st_we = ok;
                if (ok && (count_reg != '0)) begin
                    count_next = count_reg - CW'(1);
                end
            end
            sirt_pkg::CMD_GET: begin
                ok = match;
                if (ok) begin
                    res.entry_state      = rd_status;
                    res.entry_descriptor = rd_payload.descriptor;
                    res.first_sent_time  = rd_payload.sent_time;
                end
            end
            sirt_pkg::CMD_SET_STATE: begin
                ok     = match && (s1_state_reg != sirt_pkg::SLOT_EMPTY);
                st_we  = ok;
                st_val = s1_state_reg;
            end
            sirt_pkg::CMD_CLEAR: begin
                ok          = 1'b1;
                start_sweep = 1'b1;
                count_next  = '0;
            end
            default: begin
                ok = 1'b0;
            end
        endcase
        if (ok) begin
            res.status = sirt_pkg::STATUS_OK;
        end
        res.occupancy = sirt_pkg::OCC_W'(count_next);
        if (!done) begin
            count_next  = count_reg;
            start_sweep = 1'b0;
        end
    end

    assign res_valid = done;

    // Sweep owns the write port; it never overlaps a command in flight.
    always_comb begin
        wr_payload.tag        = s1_seq_reg;
        wr_payload.descriptor = s1_desc_reg;
        wr_payload.sent_time  = s1_time_reg;
        if (sweep_reg) begin
            wr_ctl.status_we  = 1'b1;
            wr_ctl.payload_we = 1'b0;
            wr_addr           = sweep_addr_reg;
            wr_status         = sirt_pkg::SLOT_EMPTY;
        end else begin
            wr_ctl.status_we  = done && st_we;
            wr_ctl.payload_we = done && pl_we;
            wr_addr           = s1_idx_reg;
            wr_status         = st_val;
        end
    end

    always_comb begin
        s1_valid_next   = s1_valid_reg;
        sweep_next      = sweep_reg;
        sweep_addr_next = sweep_addr_reg;
        if (done) begin
            s1_valid_next = 1'b0;
        end
        if (accept) begin
            s1_valid_next = 1'b1;
        end
        if (sweep_reg) begin
            sweep_addr_next = sweep_addr_reg + IW'(1);
            if (sweep_addr_reg == IW'(DEPTH - 1)) begin
                sweep_next = 1'b0;
            end
        end
        if (start_sweep) begin
            sweep_next      = 1'b1;
            sweep_addr_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg   <= 1'b0;
            count_reg      <= '0;
            sweep_reg      <= 1'b1;
            sweep_addr_reg <= '0;
        end else begin
            s1_valid_reg   <= s1_valid_next;
            count_reg      <= count_next;
            sweep_reg      <= sweep_next;
            sweep_addr_reg <= sweep_addr_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_cmd_reg   <= in_cmd;
            s1_seq_reg   <= in_seq_num;
            s1_state_reg <= in_new_state;
            s1_desc_reg  <= in_descriptor;
            s1_time_reg  <= in_now_us;
            s1_idx_reg   <= rd_addr;
        end
    end

    a_no_accept_in_sweep: assert property (@(posedge aclk) disable iff (!aresetn)
        sweep_reg |-> !accept)
        else $error("beat accepted during clear sweep");

    a_payload_wr_owner: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_ctl.payload_we |-> (s1_valid_reg && !sweep_reg))
        else $error("payload write without a command in flight");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(DEPTH))
        else $error("occupancy count beyond depth");

    a_clear_starts_sweep: assert property (@(posedge aclk) disable iff (!aresetn)
        (done && (s1_cmd_reg == sirt_pkg::CMD_CLEAR)) |=> (sweep_reg && (count_reg == '0)))
        else $error("clear did not start sweep");

    a_done_frees_stage: assert property (@(posedge aclk) disable iff (!aresetn)
        done |=> !s1_valid_reg)
        else $error("command stage not freed after result");

endmodule

`default_nettype wire

// ----- design/seq_indexed_retransmit_table_unit.sv -----
// Result path: slot read registered at the accepting edge, then update and result register
// written together; a busy result register stalls the stage.
// Slot read-modify-write is interlocked: no command is accepted while one is in flight.
// Clear-all and reset run a sweep over all DEPTH slot states; no input beat
// is accepted during it, configuration writes still are.
// Top level: log2_capacity register, result register;
// uses sirt_pkg, sirt_cmd_unit, sirt_slot_mem.
`timescale 1ns / 1ps
`default_nettype none

module seq_indexed_retransmit_table_unit #(
    parameter int DEPTH = sirt_pkg::DEPTH_DEFAULT
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_we,
    input  wire logic [sirt_pkg::CFG_W-1:0]      cfg_wdata,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic [sirt_pkg::CMD_W-1:0]      s_cmd,
    input  wire logic [sirt_pkg::SEQ_W-1:0]      s_seq_num,
    input  wire logic [sirt_pkg::STATE_W-1:0]    s_new_state,
    input  wire logic [sirt_pkg::DESC_W-1:0]     s_packet_descriptor,
    input  wire logic [sirt_pkg::TIME_W-1:0]     s_now_us,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic                                 m_status,
    output logic [sirt_pkg::STATE_W-1:0]         m_entry_state,
    output logic [sirt_pkg::DESC_W-1:0]          m_entry_descriptor,
    output logic [sirt_pkg::TIME_W-1:0]          m_first_sent_time,
    output logic [sirt_pkg::OCC_W-1:0]           m_occupancy
);

    localparam int IW = $clog2(DEPTH);

    logic [sirt_pkg::CFG_W-1:0] log2_cap_reg;
    logic                       m_valid_reg, m_valid_next;
    sirt_pkg::sirt_result_t     res_reg;

    logic                         out_free;
    logic                         res_valid;
    sirt_pkg::sirt_result_t       res;
    logic                         rd_en;
    logic [IW-1:0]                rd_addr;
    logic [sirt_pkg::STATE_W-1:0] rd_status;
    sirt_pkg::sirt_payload_t      rd_payload;
    sirt_pkg::sirt_wr_ctl_t       wr_ctl;
    logic [IW-1:0]                wr_addr;
    logic [sirt_pkg::STATE_W-1:0] wr_status;
    sirt_pkg::sirt_payload_t      wr_payload;

    assign out_free = !m_valid_reg || m_ready;

    sirt_cmd_unit #(
        .DEPTH (DEPTH)
    ) u_cmd (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .log2_capacity (log2_cap_reg),
        .in_valid      (s_valid),
        .in_ready      (s_ready),
        .in_cmd        (s_cmd),
        .in_seq_num    (s_seq_num),
        .in_new_state  (s_new_state),
        .in_descriptor (s_packet_descriptor),
        .in_now_us     (s_now_us),
        .out_free      (out_free),
        .res_valid     (res_valid),
        .res           (res),
        .rd_en         (rd_en),
        .rd_addr       (rd_addr),
        .rd_status     (rd_status),
        .rd_payload    (rd_payload),
        .wr_ctl        (wr_ctl),
        .wr_addr       (wr_addr),
        .wr_status     (wr_status),
        .wr_payload    (wr_payload)
    );

    sirt_slot_mem #(
        .DEPTH (DEPTH)
    ) u_mem (
        .aclk       (aclk),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .rd_status  (rd_status),
        .rd_payload (rd_payload),
        .wr_ctl     (wr_ctl),
        .wr_addr    (wr_addr),
        .wr_status  (wr_status),
        .wr_payload (wr_payload)
    );

    always_comb begin
        m_valid_next = m_valid_reg;
        if (res_valid) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            log2_cap_reg <= sirt_pkg::LOG2_CAP_RESET;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cfg_we) begin
                log2_cap_reg <= cfg_wdata;
            end
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid) begin
            res_reg <= res;
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_status           = res_reg.status;
    assign m_entry_state      = res_reg.entry_state;
    assign m_entry_descriptor = res_reg.entry_descriptor;
    assign m_first_sent_time  = res_reg.first_sent_time;
    assign m_occupancy        = res_reg.occupancy;

endmodule

`default_nettype wire

// ----- test/sirt_reply_checker.sv -----
// sirt_reply_checker: watches both channels of the retransmit table, keeps its own copy of the
// slot table and capacity register, and compares every result beat against the prediction.
// Depends on sirt_pkg.
`timescale 1ns / 1ps

module sirt_reply_checker #(
    parameter int DEPTH = sirt_pkg::DEPTH_DEFAULT
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         cfg_we,
    input  wire logic [sirt_pkg::CFG_W-1:0]   cfg_wdata,
    input  wire logic                         s_valid,
    input  wire logic                         s_ready,
    input  wire logic [sirt_pkg::CMD_W-1:0]   s_cmd,
    input  wire logic [sirt_pkg::SEQ_W-1:0]   s_seq_num,
    input  wire logic [sirt_pkg::STATE_W-1:0] s_new_state,
    input  wire logic [sirt_pkg::DESC_W-1:0]  s_packet_descriptor,
    input  wire logic [sirt_pkg::TIME_W-1:0]  s_now_us,
    input  wire logic                         m_valid,
    input  wire logic                         m_ready,
    input  wire logic                         m_status,
    input  wire logic [sirt_pkg::STATE_W-1:0] m_entry_state,
    input  wire logic [sirt_pkg::DESC_W-1:0]  m_entry_descriptor,
    input  wire logic [sirt_pkg::TIME_W-1:0]  m_first_sent_time,
    input  wire logic [sirt_pkg::OCC_W-1:0]   m_occupancy,
    output int                                outstanding,
    output int                                failures
);

    logic [sirt_pkg::CFG_W-1:0]   cap_log2;
    logic [sirt_pkg::STATE_W-1:0] slot_st   [DEPTH];
    logic [sirt_pkg::SEQ_W-1:0]   slot_tag  [DEPTH];
    logic [sirt_pkg::DESC_W-1:0]  slot_desc [DEPTH];
    logic [sirt_pkg::TIME_W-1:0]  slot_time [DEPTH];
    logic [sirt_pkg::OCC_W-1:0]   live;
    sirt_pkg::sirt_result_t       expected_replies [$];
    int                           errs = 0;

    function automatic sirt_pkg::sirt_result_t run_command(
        input logic [sirt_pkg::CMD_W-1:0]   cmd,
        input logic [sirt_pkg::SEQ_W-1:0]   seq,
        input logic [sirt_pkg::STATE_W-1:0] st,
        input logic [sirt_pkg::DESC_W-1:0]  desc,
        input logic [sirt_pkg::TIME_W-1:0]  now);
        sirt_pkg::sirt_result_t r;
        int l;
        int idx;
        logic occupied;
        logic hit;
        l = int'(cap_log2);
        if (l < sirt_pkg::MIN_LOG2) l = sirt_pkg::MIN_LOG2;
        while ((1 << l) > DEPTH) l--;
        idx = int'(seq & 32'((1 << l) - 1));
        r = '0;
        r.status = sirt_pkg::STATUS_FAIL;
        occupied = slot_st[idx] != sirt_pkg::SLOT_EMPTY;
        hit = occupied && (slot_tag[idx] == seq);
        case (cmd)
            sirt_pkg::CMD_INSERT: begin
                if (!occupied && st != sirt_pkg::SLOT_EMPTY) begin
                    slot_st[idx]   = st;
                    slot_tag[idx]  = seq;
                    slot_desc[idx] = desc;
                    slot_time[idx] = now;
                    live++;
                    r.status = sirt_pkg::STATUS_OK;
                end
            end
            sirt_pkg::CMD_REMOVE: begin
                if (occupied) begin
                    slot_st[idx] = sirt_pkg::SLOT_EMPTY;
                    if (live != 0) live--;
                    r.status = sirt_pkg::STATUS_OK;
                end
            end
            sirt_pkg::CMD_GET: begin
                if (hit) begin
                    r.entry_state      = slot_st[idx];
                    r.entry_descriptor = slot_desc[idx];
                    r.first_sent_time  = slot_time[idx];
                    r.status           = sirt_pkg::STATUS_OK;
                end
            end
            sirt_pkg::CMD_SET_STATE: begin
                if (hit && st != sirt_pkg::SLOT_EMPTY) begin
                    slot_st[idx] = st;
                    r.status = sirt_pkg::STATUS_OK;
                end
            end
            sirt_pkg::CMD_CLEAR: begin
                for (int i = 0; i < DEPTH; i++) slot_st[i] = sirt_pkg::SLOT_EMPTY;
                live = '0;
                r.status = sirt_pkg::STATUS_OK;
            end
            default: ;
        endcase
        r.occupancy = live;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            errs++;
        end
    endtask

    always @(posedge aclk) begin
        sirt_pkg::sirt_result_t want;
        if (!aresetn) begin
            cap_log2 = sirt_pkg::LOG2_CAP_RESET;
            for (int i = 0; i < DEPTH; i++) slot_st[i] = sirt_pkg::SLOT_EMPTY;
            live = '0;
            expected_replies.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (expected_replies.size() == 0) begin
                    $error("result beat with no command outstanding");
                    errs++;
                end else begin
                    want = expected_replies.pop_front();
                    check_field("status", want.status, m_status);
                    check_field("entry_state", want.entry_state, m_entry_state);
                    check_field("entry_descriptor", want.entry_descriptor, m_entry_descriptor);
                    check_field("first_sent_time", want.first_sent_time, m_first_sent_time);
                    check_field("occupancy", want.occupancy, m_occupancy);
                end
            end
            // a beat accepted at this edge still sees the old capacity
            if (s_valid && s_ready) begin
                expected_replies.push_back(run_command(s_cmd, s_seq_num, s_new_state,
                                                       s_packet_descriptor, s_now_us));
            end
            if (cfg_we) cap_log2 = cfg_wdata;
        end
        outstanding <= expected_replies.size();
        failures <= errs;
    end

endmodule

// ----- test/testbench.sv -----
// testbench: drives commands into the retransmit table under several capacity settings and
// idle mixes, with a receiver hold-off and drain pauses; sirt_reply_checker does the comparing.
// Depends on sirt_pkg, sirt_reply_checker and seq_indexed_retransmit_table_unit.
`timescale 1ns / 1ps

module testbench;

    localparam int HOLD_CYCLES  = 320;
    localparam int QUIET_LIMIT  = 5000;
    localparam int SEG_ITEMS    = 130;
    localparam int POOL_SIZE    = 16;

    logic                          aclk;
    logic                          aresetn             = 1'b0;
    logic                          cfg_we              = 1'b0;
    logic [sirt_pkg::CFG_W-1:0]    cfg_wdata           = sirt_pkg::LOG2_CAP_RESET;
    logic                          s_valid             = 1'b0;
    logic                          s_ready;
    logic [sirt_pkg::CMD_W-1:0]    s_cmd               = sirt_pkg::CMD_GET;
    logic [sirt_pkg::SEQ_W-1:0]    s_seq_num           = '0;
    logic [sirt_pkg::STATE_W-1:0]  s_new_state         = sirt_pkg::SLOT_EMPTY;
    logic [sirt_pkg::DESC_W-1:0]   s_packet_descriptor = '0;
    logic [sirt_pkg::TIME_W-1:0]   s_now_us            = '0;
    logic                          m_valid;
    logic                          m_ready             = 1'b0;
    logic                          m_status;
    logic [sirt_pkg::STATE_W-1:0]  m_entry_state;
    logic [sirt_pkg::DESC_W-1:0]   m_entry_descriptor;
    logic [sirt_pkg::TIME_W-1:0]   m_first_sent_time;
    logic [sirt_pkg::OCC_W-1:0]    m_occupancy;

    int outstanding;
    int failures;

    int tx_idle_pct  = 0;
    int rx_idle_pct  = 0;
    int hold_req     = 0;
    int hold_seen    = 0;
    int hold_left    = 0;
    int quiet_cycles = 0;
    int items        = 0;
    int clears       = 0;
    int caps_written = 0;
    logic [sirt_pkg::SEQ_W-1:0] seq_pool [POOL_SIZE];

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    seq_indexed_retransmit_table_unit i_dut (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cfg_we              (cfg_we),
        .cfg_wdata           (cfg_wdata),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_cmd               (s_cmd),
        .s_seq_num           (s_seq_num),
        .s_new_state         (s_new_state),
        .s_packet_descriptor (s_packet_descriptor),
        .s_now_us            (s_now_us),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_status            (m_status),
        .m_entry_state       (m_entry_state),
        .m_entry_descriptor  (m_entry_descriptor),
        .m_first_sent_time   (m_first_sent_time),
        .m_occupancy         (m_occupancy)
    );

    sirt_reply_checker i_checker (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cfg_we              (cfg_we),
        .cfg_wdata           (cfg_wdata),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_cmd               (s_cmd),
        .s_seq_num           (s_seq_num),
        .s_new_state         (s_new_state),
        .s_packet_descriptor (s_packet_descriptor),
        .s_now_us            (s_now_us),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_status            (m_status),
        .m_entry_state       (m_entry_state),
        .m_entry_descriptor  (m_entry_descriptor),
        .m_first_sent_time   (m_first_sent_time),
        .m_occupancy         (m_occupancy),
        .outstanding         (outstanding),
        .failures            (failures)
    );

    // receiver: random back-pressure, or a long hold-off when one is requested
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_seen != hold_req) begin
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES;
            m_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
            $display("watchdog: no beat moved for %0d cycles", QUIET_LIMIT);
            $display("testbench failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_beat(input logic [sirt_pkg::CMD_W-1:0] c,
                             input logic [sirt_pkg::SEQ_W-1:0] seq,
                             input logic [sirt_pkg::STATE_W-1:0] st,
                             input logic [sirt_pkg::DESC_W-1:0] desc,
                             input logic [sirt_pkg::TIME_W-1:0] now);
        int gap;
        gap = 0;
        while ($urandom_range(99) < tx_idle_pct) gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_cmd <= c;
        s_seq_num <= seq;
        s_new_state <= st;
        s_packet_descriptor <= desc;
        s_now_us <= now;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items++;
        if (c == sirt_pkg::CMD_CLEAR) clears++;
    endtask

    task automatic drain_replies();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
    endtask

    task automatic write_cap(input logic [sirt_pkg::CFG_W-1:0] v);
        repeat (4) @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we <= 1'b0;
        caps_written++;
    endtask

    task automatic send_random_command();
        int r;
        int slot;
        int pick;
        logic [sirt_pkg::CMD_W-1:0]   c;
        logic [sirt_pkg::SEQ_W-1:0]   seq;
        logic [sirt_pkg::STATE_W-1:0] st;
        r = $urandom_range(99);
        if (r < 30) c = sirt_pkg::CMD_INSERT;
        else if (r < 45) c = sirt_pkg::CMD_REMOVE;
        else if (r < 72) c = sirt_pkg::CMD_GET;
        else if (r < 92) c = sirt_pkg::CMD_SET_STATE;
        else if (r < 94) c = sirt_pkg::CMD_CLEAR;
        else c = sirt_pkg::CMD_CLEAR + sirt_pkg::CMD_W'($urandom_range(1, 3));
        slot = $urandom_range(POOL_SIZE - 1);
        pick = $urandom_range(9);
        if ((c == sirt_pkg::CMD_INSERT && pick < 6) || pick >= 8) seq = $urandom();
        else if (pick == 7) seq = seq_pool[slot] ^ ($urandom() << 8);
        else seq = seq_pool[slot];
        st = ($urandom_range(9) == 0) ? sirt_pkg::SLOT_EMPTY
                                      : sirt_pkg::STATE_W'($urandom_range(1, 3));
        if (c == sirt_pkg::CMD_INSERT) seq_pool[slot] = seq;
        send_beat(c, seq, st, $urandom(), $urandom());
    endtask

    // one packet's life: insert, look up, change state, look up, maybe drop
    task automatic send_lifecycle();
        logic [sirt_pkg::SEQ_W-1:0] seq;
        seq = $urandom();
        seq_pool[$urandom_range(POOL_SIZE - 1)] = seq;
        send_beat(sirt_pkg::CMD_INSERT, seq, sirt_pkg::STATE_W'($urandom_range(1, 3)),
                  $urandom(), $urandom());
        send_beat(sirt_pkg::CMD_GET, seq, sirt_pkg::STATE_W'($urandom()),
                  $urandom(), $urandom());
        send_beat(sirt_pkg::CMD_SET_STATE, seq, sirt_pkg::STATE_W'($urandom_range(1, 3)),
                  $urandom(), $urandom());
        send_beat(sirt_pkg::CMD_GET, seq, sirt_pkg::STATE_W'($urandom()),
                  $urandom(), $urandom());
        if ($urandom_range(1) == 1)
            send_beat(sirt_pkg::CMD_REMOVE, seq, sirt_pkg::STATE_W'($urandom()),
                      $urandom(), $urandom());
    endtask

    initial begin
        int cap_plan [7];
        int seg_start;
        cap_plan = '{2, 8, 0, 15, 8, 5, 0};
        cap_plan[6] = $urandom_range(15);
        for (int i = 0; i < POOL_SIZE; i++) seq_pool[i] = $urandom();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: reset capacity, empty-slot failures, extremes, tag mismatch, bad codes
        send_beat(sirt_pkg::CMD_GET, '0, sirt_pkg::SLOT_EMPTY, '0, '0);
        send_beat(sirt_pkg::CMD_REMOVE, '0, sirt_pkg::SLOT_EMPTY, '0, '0);
        send_beat(sirt_pkg::CMD_SET_STATE, '0, 2'd1, '0, '0);
        send_beat(sirt_pkg::CMD_INSERT, '1, 2'd3, '1, '1);
        send_beat(sirt_pkg::CMD_INSERT, '1, 2'd2, 32'h1234, 32'h5678);
        send_beat(sirt_pkg::CMD_GET, '1, sirt_pkg::SLOT_EMPTY, '0, '0);
        send_beat(sirt_pkg::CMD_GET, 32'h0000_00ff, sirt_pkg::SLOT_EMPTY, '0, '0);
        send_beat(sirt_pkg::CMD_SET_STATE, '1, sirt_pkg::SLOT_EMPTY, '0, '0);
        send_beat(sirt_pkg::CMD_SET_STATE, '1, 2'd1, '0, '0);
        send_beat(sirt_pkg::CMD_GET, '1, 2'd3, '1, '1);
        send_beat(sirt_pkg::CMD_INSERT, '0, sirt_pkg::SLOT_EMPTY, 32'hdead_beef, 32'h1);
        send_beat(sirt_pkg::CMD_INSERT, '0, 2'd1, '0, '0);
        send_beat(sirt_pkg::CMD_GET, '0, sirt_pkg::SLOT_EMPTY, '1, '1);
        send_beat(sirt_pkg::CMD_CLEAR + 3'd1, '0, 2'd1, '0, '0);
        send_beat(sirt_pkg::CMD_CLEAR + 3'd2, '1, 2'd2, '1, '1);
        send_beat(sirt_pkg::CMD_CLEAR + 3'd3, '0, 2'd3, '0, '0);
        send_beat(sirt_pkg::CMD_SET_STATE, 32'h0000_0100, 2'd2, '0, '0);
        send_beat(sirt_pkg::CMD_REMOVE, 32'h0000_0100, sirt_pkg::SLOT_EMPTY, '0, '0);
        send_beat(sirt_pkg::CMD_GET, '0, sirt_pkg::SLOT_EMPTY, '0, '0);
        send_beat(sirt_pkg::CMD_INSERT, 32'h1234_5678, 2'd2, 32'h8765_4321, 32'h0f0f_0f0f);
        send_beat(sirt_pkg::CMD_CLEAR, '0, sirt_pkg::SLOT_EMPTY, '0, '0);
        send_beat(sirt_pkg::CMD_GET, '1, sirt_pkg::SLOT_EMPTY, '0, '0);
        send_beat(sirt_pkg::CMD_REMOVE, 32'h1234_5678, sirt_pkg::SLOT_EMPTY, '0, '0);
        drain_replies();

        for (int seg = 0; seg < 7; seg++) begin
            if (seg < 2) begin
                tx_idle_pct = 26;
                rx_idle_pct <= 69;
            end else if (seg < 4) begin
                tx_idle_pct = 69;
                rx_idle_pct <= 26;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct <= 0;
            end
            write_cap(sirt_pkg::CFG_W'(cap_plan[seg]));
            if (seg % 2 == 0) hold_req <= hold_req + 1;
            if (seg == 4) begin
                // fill every slot at full capacity
                send_beat(sirt_pkg::CMD_CLEAR, $urandom(), sirt_pkg::SLOT_EMPTY,
                          $urandom(), $urandom());
                for (int i = 0; i < sirt_pkg::DEPTH_DEFAULT; i++)
                    send_beat(sirt_pkg::CMD_INSERT, ($urandom() << 8) | i,
                              sirt_pkg::STATE_W'($urandom_range(1, 3)),
                              $urandom(), $urandom());
            end
            seg_start = items;
            while (items - seg_start < SEG_ITEMS) begin
                if (items - seg_start >= SEG_ITEMS / 2 && items - seg_start < SEG_ITEMS / 2 + 6)
                    drain_replies();
                if ($urandom_range(1) == 1) send_lifecycle();
                else send_random_command();
            end
            drain_replies();
        end

        drain_replies();
        repeat (8) @(posedge aclk);
        $display("Covered %0d command beats (%0d clear-all) over %0d capacity writes,",
                 items, clears, caps_written);
        $display("out of range too; idle mixes 26/69, 69/26 and none, with receiver hold-offs.");
        if (failures == 0 && outstanding == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
design/sirt_pkg.sv
design/sirt_slot_mem.sv
design/sirt_cmd_unit.sv
design/seq_indexed_retransmit_table_unit.sv
test/sirt_reply_checker.sv
test/testbench.sv
